// ===== hdl/dcc_pkg.sv =====
// Package: shared types, constants and month length function for the day count converter.
`timescale 1ns / 1ps
package dcc_pkg;

  localparam int unsigned DAY_COUNT_W = 16;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_W      = 12;

  localparam logic [YEAR_W-1:0] BASE_YEAR   = 12'd1978;
  // 1978 mod 100 and 1978 mod 400
  localparam logic [6:0]        BASE_MOD100 = 7'd78;
  localparam logic [8:0]        BASE_MOD400 = 9'd378;
  localparam logic [6:0]        MOD100_LAST = 7'd99;
  localparam logic [8:0]        MOD400_LAST = 9'd399;

  localparam logic [8:0] DAYS_YEAR = 9'd365;
  localparam logic [8:0] DAYS_LEAP = 9'd366;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
  localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_EMIT
  } dcc_state_t;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic emit;
  } dcc_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } dcc_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      len = LEN_SHORT;
    end else if (m == MONTH_FEB) begin
      len = leap ? LEN_FEB_LEAP : LEN_FEB;
    end else begin
      len = LEN_LONG;
    end
    return len;
  endfunction

endpackage

// ===== hdl/day_count_to_calendar_date_unit.sv =====
// Top level: day count to Gregorian calendar date converter.
//
// Usage: present a 16-bit day count on in_day_count with in_valid high; day 1
// is 1 January 1978 and a count of 0 reads as day 0 of January 1978. The item
// is taken at a rising edge where in_valid is high and in_stall is low. One
// result item follows on out_day_of_month, out_month_number and
// out_year_number, handed over at an edge where out_valid is high and
// out_stall is low.
// Conversion: the accepting edge loads the count; the years state then takes
// off one whole year per step until the remainder fits in a year, the months
// state takes off one whole month per step until it fits in the month or the
// month is December, and the emit state moves the result into the output
// register and raises out_valid. One item is in conversion at a time and the
// input reopens when the result is registered.
// The output register parts the channels: a new item is taken while the last
// result still waits; if the receiver stalls, the result holds and the
// finished conversion waits in the controller until the register frees.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; no other state is kept between items.
`timescale 1ns / 1ps
module day_count_to_calendar_date_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dcc_pkg::DAY_COUNT_W-1:0] in_day_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dcc_pkg::DAY_W-1:0]       out_day_of_month,
  output logic [dcc_pkg::MONTH_W-1:0]     out_month_number,
  output logic [dcc_pkg::YEAR_W-1:0]      out_year_number
);
  import dcc_pkg::*;

  dcc_cmd_t cmd;
  dcc_sts_t sts;

  // Controller: walks idle, years, months, emit
  dcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: remainder and counters, plus the output register
  dcc_dpath u_dpath (
    .clk              (clk),
    .in_day_count     (in_day_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_day_of_month (out_day_of_month),
    .out_month_number (out_month_number),
    .out_year_number  (out_year_number)
  );

  // an accepted item closes the input until its conversion is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after accepting an item");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= MONTH_JAN) && (out_month_number <= MONTH_DEC))
    else $error("month out of range");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year_number >= BASE_YEAR) && (out_year_number <= 12'd2157))
    else $error("year out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== hdl/dcc_ctrl.sv =====
// Controller: sequences load, year stepping, month stepping and result hand-off.
`timescale 1ns / 1ps
module dcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dcc_pkg::dcc_sts_t sts,
  output dcc_pkg::dcc_cmd_t cmd
);
  import dcc_pkg::*;

  dcc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_YEARS;
        end
      end
      ST_YEARS: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = ST_MONTHS;
        end
      end
      ST_MONTHS: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free or being taken
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/dcc_dpath.sv =====
// Datapath: remainder, year and month counters, leap test and output register.
`timescale 1ns / 1ps
module dcc_dpath (
  input  logic                                clk,
  input  logic [dcc_pkg::DAY_COUNT_W-1:0]     in_day_count,
  input  dcc_pkg::dcc_cmd_t                   cmd,
  output dcc_pkg::dcc_sts_t                   sts,
  output logic [dcc_pkg::DAY_W-1:0]           out_day_of_month,
  output logic [dcc_pkg::MONTH_W-1:0]         out_month_number,
  output logic [dcc_pkg::YEAR_W-1:0]          out_year_number
);
  import dcc_pkg::*;

  logic [DAY_COUNT_W-1:0] rem_r;
  logic [YEAR_W-1:0]      year_r;
  logic [6:0]             mod100_r;
  logic [8:0]             mod400_r;
  logic [MONTH_W-1:0]     month_r;
  logic [DAY_W-1:0]       day_out_r;
  logic [MONTH_W-1:0]     month_out_r;
  logic [YEAR_W-1:0]      year_out_r;

  logic                   leap;
  logic [8:0]             year_len;
  logic [DAY_W-1:0]       mon_len;

  // divisible by 4 and not by 100, or divisible by 400
  assign leap     = ((year_r[1:0] == 2'b00) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign year_len = leap ? DAYS_LEAP : DAYS_YEAR;
  assign mon_len  = month_len(month_r, leap);

  always_comb begin
    sts.year_more  = (rem_r > {7'd0, DAYS_YEAR}) &&
                     ((rem_r != {7'd0, DAYS_LEAP}) || !leap);
    sts.month_more = (rem_r > {11'd0, mon_len}) && (month_r < MONTH_DEC);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r    <= in_day_count;
      year_r   <= BASE_YEAR;
      mod100_r <= BASE_MOD100;
      mod400_r <= BASE_MOD400;
      month_r  <= MONTH_JAN;
    end else if (cmd.year_step) begin
      rem_r    <= rem_r - {7'd0, year_len};
      year_r   <= year_r + 12'd1;
      mod100_r <= (mod100_r == MOD100_LAST) ? 7'd0 : mod100_r + 7'd1;
      mod400_r <= (mod400_r == MOD400_LAST) ? 9'd0 : mod400_r + 9'd1;
    end else if (cmd.month_step) begin
      rem_r   <= rem_r - {11'd0, mon_len};
      month_r <= month_r + 4'd1;
    end
    if (cmd.emit) begin
      day_out_r   <= rem_r[DAY_W-1:0];
      month_out_r <= month_r;
      year_out_r  <= year_r;
    end
  end

  assign out_day_of_month = day_out_r;
  assign out_month_number = month_out_r;
  assign out_year_number  = year_out_r;

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the day count to calendar date converter: directed and random items, self-checked.
`timescale 1ns / 1ps
module tb_top;
  import dcc_pkg::*;

  // Cycles without any item moving on either channel before the run is
  // declared hung; this leaves a wide margin over the slowest item and the
  // long receiver hold.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Cycles to idle after the last result, about one full conversion.
  localparam int unsigned DRAIN_CYCLES   = 250;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned IDLE_PERCENT   = 37;
  localparam int unsigned LAST_YEAR      = 2157;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } calendar_date_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [DAY_COUNT_W-1:0] in_day_count = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DAY_W-1:0]       out_day_of_month;
  logic [MONTH_W-1:0]     out_month_number;
  logic [YEAR_W-1:0]      out_year_number;

  // Dates still owed by the block, oldest first.
  calendar_date_t pending_dates[$];
  int unsigned    mismatch_count = 0;
  // Set by the tests to switch off idling on both channels.
  bit             steady_flow = 1'b0;
  // Each increment asks the receiver for one long hold.
  int unsigned    hold_requests = 0;

  day_count_to_calendar_date_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_day_count     (in_day_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_day_of_month (out_day_of_month),
    .out_month_number (out_month_number),
    .out_year_number  (out_year_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned mon,
                                                input int unsigned yr);
    if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP || mon == MONTH_NOV) begin
      return LEN_SHORT;
    end else if (mon == MONTH_FEB) begin
      return is_leap_year(yr) ? LEN_FEB_LEAP : LEN_FEB;
    end
    return LEN_LONG;
  endfunction

  // Strip whole years, then whole months, off the count. A remainder of
  // exactly 366 in a leap year is its last day and stays in that year;
  // December never rolls over, so the remainder is the day of month.
  function automatic calendar_date_t predict_calendar_date(input logic [DAY_COUNT_W-1:0] count);
    int unsigned    rem;
    int unsigned    yr;
    int unsigned    mon;
    int unsigned    len;
    calendar_date_t date;
    rem = count;
    yr  = BASE_YEAR;
    mon = MONTH_JAN;
    while (rem > DAYS_YEAR && (rem != DAYS_LEAP || !is_leap_year(yr))) begin
      rem -= is_leap_year(yr) ? DAYS_LEAP : DAYS_YEAR;
      yr++;
    end
    len = days_in_month(mon, yr);
    while (rem > len && mon < MONTH_DEC) begin
      rem -= len;
      mon++;
      len = days_in_month(mon, yr);
    end
    date.day   = rem[DAY_W-1:0];
    date.month = mon[MONTH_W-1:0];
    date.year  = yr[YEAR_W-1:0];
    return date;
  endfunction

  // Inverse mapping for building stimulus at chosen dates; clip to the
  // top of the 16-bit range for dates past it.
  function automatic logic [DAY_COUNT_W-1:0] count_of_date(input int unsigned yr,
                                                           input int unsigned mon,
                                                           input int unsigned day);
    int unsigned total;
    total = day;
    for (int unsigned y = BASE_YEAR; y < yr; y++) begin
      total += is_leap_year(y) ? DAYS_LEAP : DAYS_YEAR;
    end
    for (int unsigned m = MONTH_JAN; m < mon; m++) begin
      total += days_in_month(m, yr);
    end
    if (total > {DAY_COUNT_W{1'b1}}) begin
      total = {DAY_COUNT_W{1'b1}};
    end
    return total[DAY_COUNT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one day count and hold it until taken. Idle gaps come first, so
  // in_valid is only lowered in a step where it is not also raised.
  task automatic send_day_count(input logic [DAY_COUNT_W-1:0] count);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_day_count <= count;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_dates.push_back(predict_calendar_date(count));
  endtask

  // Pick a count near a year or month boundary, or anywhere in range.
  function automatic logic [DAY_COUNT_W-1:0] random_day_count();
    int unsigned yr;
    int unsigned mon;
    int unsigned pick;
    yr   = $urandom_range(LAST_YEAR, BASE_YEAR);
    mon  = $urandom_range(MONTH_DEC, MONTH_JAN);
    pick = $urandom_range(9);
    case (pick)
      0: begin
        return count_of_date(yr, MONTH_DEC, LEN_LONG);
      end
      1: begin
        return count_of_date(yr, MONTH_JAN, 1);
      end
      2: begin
        return count_of_date(yr, mon, days_in_month(mon, yr));
      end
      3: begin
        return count_of_date(yr, MONTH_FEB, $urandom_range(LEN_FEB_LEAP, LEN_FEB));
      end
      4: begin
        return DAY_COUNT_W'($urandom_range(2 * DAYS_LEAP, 0));
      end
      default: begin
        return DAY_COUNT_W'($urandom_range({DAY_COUNT_W{1'b1}}, 0));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------

  // Stall at random, or for a long stretch when a hold is asked for; the
  // length of the hold is counted here, not by the test.
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall    <= 1'b1;
      hold_left    <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Match every handed-over result against the oldest owed date.
  always @(posedge clk) begin
    calendar_date_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result with nothing owed: day %0d month %0d year %0d",
                 $time, out_day_of_month, out_month_number, out_year_number);
        mismatch_count++;
      end else begin
        owed = pending_dates.pop_front();
        if (out_day_of_month !== owed.day) begin
          $display("%0t: day_of_month expected %0d actual %0d",
                   $time, owed.day, out_day_of_month);
          mismatch_count++;
        end
        if (out_month_number !== owed.month) begin
          $display("%0t: month_number expected %0d actual %0d",
                   $time, owed.month, out_month_number);
          mismatch_count++;
        end
        if (out_year_number !== owed.year) begin
          $display("%0t: year_number expected %0d actual %0d",
                   $time, owed.year, out_year_number);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles in which no item moves on either channel; end a hung run.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Edges of the count range, year and month boundaries, and the leap rule
  // for ordinary, century and 400-year cases.
  task automatic test_directed_dates();
    send_day_count('0);                       // day zero of January 1978
    send_day_count(DAY_COUNT_W'(1));
    send_day_count(DAY_COUNT_W'(DAYS_YEAR));  // last day of a common year
    send_day_count(DAY_COUNT_W'(DAYS_LEAP));  // first day of the next year
    send_day_count({DAY_COUNT_W{1'b1}});      // largest count
    send_day_count({1'b1, {(DAY_COUNT_W-1){1'b0}}});
    send_day_count({1'b0, {(DAY_COUNT_W-1){1'b1}}});
    send_day_count(count_of_date(1980, MONTH_DEC, LEN_LONG));  // leap year ends on 366
    send_day_count(count_of_date(1981, MONTH_JAN, 1));
    send_day_count(count_of_date(1980, MONTH_FEB, LEN_FEB_LEAP));
    send_day_count(count_of_date(1980, 3, 1));
    send_day_count(count_of_date(1979, MONTH_FEB, LEN_FEB));
    send_day_count(count_of_date(2000, MONTH_FEB, LEN_FEB_LEAP));
    send_day_count(count_of_date(2100, MONTH_FEB, LEN_FEB));
    send_day_count(count_of_date(2100, 3, 1));
    // Last day of each month in one common year.
    for (int unsigned m = MONTH_JAN; m <= MONTH_DEC; m++) begin
      send_day_count(count_of_date(1990, m, days_in_month(m, 1990)));
    end
  endtask

  task automatic test_random_counts(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_day_count(random_day_count());
    end
  endtask

  // Back-to-back items with the receiver never stalling.
  task automatic test_steady_flow(input int unsigned count);
    steady_flow = 1'b1;
    test_random_counts(count);
    steady_flow = 1'b0;
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so
  // the output register and controller fill and the input stalls.
  task automatic test_output_backpressure(input int unsigned count);
    hold_requests++;
    test_random_counts(count);
  endtask

  initial begin
    // Hold reset low at the start, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_dates();
    test_random_counts(1200);
    test_steady_flow(300);
    test_output_backpressure(200);

    // Drop valid and wait for the last results to drain.
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
